// File: design/assert_macros.svh
// Assertion macros shared by the UTF-8 decoder RTL.
// Each macro expects clk and rst_n to be visible at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds whenever the antecedent holds in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/u8d_pkg.sv
// Package for the UTF-8 stream decoder: status codes, limits and stage types.
// Used by every module of the decoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned REM_W  = 2;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;

    typedef enum logic [2:0] {
        ST_VALID        = 3'd0,
        ST_EXPECT_CONT  = 3'd1,
        ST_OUT_OF_RANGE = 3'd2,
        ST_SURROGATE    = 3'd3,
        ST_OVERLONG     = 3'd4,
        ST_INVALID_BYTE = 3'd5
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } in_beat_t;

    typedef struct packed {
        logic [LEN_W-1:0]  sequence_length;
        logic [BYTE_W-1:0] error_byte;
        logic [CP_W-1:0]   char_value;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

// File: design/u8d_in_stage.sv
// Input register of the UTF-8 decoder: holds one accepted byte for the decode step.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_in_stage
    import u8d_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [BYTE_W-1:0] s_axis_tdata,
    input  wire logic              take,
    output in_beat_t               beat
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              load;

    assign s_axis_tready = !valid_reg || take;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= s_axis_tdata;
        end
    end

    assign beat.valid = valid_reg;
    assign beat.data  = data_reg;

endmodule

`default_nettype wire

// File: design/u8d_core.sv
// Decode step of the UTF-8 decoder: sequence state registers and the per-byte logic.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_core
    import u8d_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_beat_t beat,
    input  wire logic     take,
    output logic          res_valid,
    output result_t       res
);

    logic [CP_W-1:0]  partial_reg;
    logic [CP_W-1:0]  partial_next;
    logic [REM_W-1:0] remaining_reg;
    logic [REM_W-1:0] remaining_next;
    logic [LEN_W-1:0] collected_reg;
    logic [LEN_W-1:0] collected_next;

    logic [BYTE_W-1:0] b;
    logic [CP_W-1:0]   cp_cont;
    logic [LEN_W-1:0]  len_inc;
    logic [REM_W-1:0]  rem_dec;
    logic              is_overlong;

    assign b       = beat.data;
    assign cp_cont = {partial_reg[CP_W-7:0], b[5:0]};
    assign len_inc = collected_reg + 3'd1;
    assign rem_dec = remaining_reg - 2'd1;

    assign is_overlong = ((cp_cont < MIN_2BYTE) && (len_inc > 3'd1))
                      || ((cp_cont < MIN_3BYTE) && (len_inc > 3'd2))
                      || ((cp_cont < MIN_4BYTE) && (len_inc > 3'd3));

    always_comb
    begin
        partial_next        = partial_reg;
        remaining_next      = remaining_reg;
        collected_next      = collected_reg;
        res_valid           = 1'b0;
        res.status          = ST_VALID;
        res.char_value      = '0;
        res.error_byte      = b;
        res.sequence_length = 3'd1;

        if (!b[7])
        begin
            res_valid = 1'b1;
            if (remaining_reg != '0)
            begin
                remaining_next = '0;
                res.status     = ST_EXPECT_CONT;
            end
            else
            begin
                res.char_value = {{(CP_W-BYTE_W){1'b0}}, b};
            end
        end
        else if (b[7:6] == 2'b10)
        begin
            if (remaining_reg != '0)
            begin
                partial_next   = cp_cont;
                collected_next = len_inc;
                remaining_next = rem_dec;
                if (rem_dec == '0)
                begin
                    res_valid           = 1'b1;
                    res.char_value      = cp_cont;
                    res.sequence_length = len_inc;
                    if (cp_cont > CP_MAX)
                    begin
                        res.status = ST_OUT_OF_RANGE;
                    end
                    else if ((cp_cont >= SURR_LO) && (cp_cont <= SURR_HI))
                    begin
                        res.status = ST_SURROGATE;
                    end
                    else if (is_overlong)
                    begin
                        res.status = ST_OVERLONG;
                    end
                end
            end
        end
        else if (b[7:3] == 5'b11111)
        begin
            remaining_next = '0;
            res_valid      = 1'b1;
            res.status     = ST_INVALID_BYTE;
        end
        else if (remaining_reg != '0)
        begin
            remaining_next = '0;
        end
        else
        begin
            collected_next = 3'd1;
            if (b[7:5] == 3'b110)
            begin
                remaining_next = 2'd1;
                partial_next   = {{(CP_W-5){1'b0}}, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                remaining_next = 2'd2;
                partial_next   = {{(CP_W-4){1'b0}}, b[3:0]};
            end
            else
            begin
                remaining_next = 2'd3;
                partial_next   = {{(CP_W-3){1'b0}}, b[2:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            remaining_reg <= '0;
            collected_reg <= '0;
        end
        else if (take)
        begin
            partial_reg   <= partial_next;
            remaining_reg <= remaining_next;
            collected_reg <= collected_next;
        end
    end

endmodule

`default_nettype wire

// File: design/u8d_out_stage.sv
// Result register of the UTF-8 decoder: holds one result beat until the sink takes it.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_out_stage
    import u8d_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire result_t                res,
    output logic                        ready,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign ready = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, res_reg};

endmodule

`default_nettype wire

// File: design/utf8_stream_decoder_validator.sv
// Top level of the UTF-8 stream decoder and validator.
// Each result beat is loaded into the output register as the byte completing it is taken.
// Throughput: one byte per cycle unless the sink stalls; decode sits between two registers.
// While a result beat waits for the sink, the byte in the input register waits as well.
// Reset (rst_n low, asynchronous) empties both registers and closes any open sequence.
// Depends on u8d_pkg, u8d_in_stage, u8d_core, u8d_out_stage and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module utf8_stream_decoder_validator
    import u8d_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [BYTE_W-1:0]      s_axis_tdata,  // [7:0] data_byte
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [2:0] status, [23:3] char_value, [31:24] error_byte, [34:32] sequence_length
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    in_beat_t beat;
    result_t  res;
    logic     res_valid;
    logic     out_ready;
    logic     take;

    assign take = beat.valid && out_ready;

    u8d_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .take          (take),
        .beat          (beat)
    );

    u8d_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .take      (take),
        .res_valid (res_valid),
        .res       (res)
    );

    u8d_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (take && res_valid),
        .res           (res),
        .ready         (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ASSERT_IMPLY(a_two_byte_range,
        m_axis_tvalid && (m_axis_tdata[2:0] == ST_VALID) && (m_axis_tdata[34:32] == 3'd2),
        (m_axis_tdata[23:3] >= MIN_2BYTE) && (m_axis_tdata[23:3] < MIN_3BYTE),
        "Valid two-byte sequence decoded outside its code point range.")
    `ASSERT_IMPLY(a_invalid_byte,
        m_axis_tvalid && (m_axis_tdata[2:0] == ST_INVALID_BYTE),
        m_axis_tdata[31:27] == 5'b11111,
        "Invalid-byte status reported for a byte below F8.")
    `ASSERT_IMPLY(a_range_len,
        m_axis_tvalid && (m_axis_tdata[2:0] == ST_OUT_OF_RANGE),
        m_axis_tdata[34:32] == 3'd4,
        "Out-of-range status reported for a sequence shorter than four bytes.")
    `ASSERT_NEXT(a_result_loaded,
        take && res_valid,
        m_axis_tvalid,
        "Decoded result did not reach the output register.")

endmodule

`default_nettype wire

// File: verif/utf8_stream_decoder_validator_tb.sv
// Self-checking testbench for the UTF-8 stream decoder and validator.
// Predicts every result beat from the byte stream and compares it with the output.
// Depends on u8d_pkg and the utf8_stream_decoder_validator RTL.
`timescale 1ns / 1ps

module utf8_stream_decoder_validator_tb;
    import u8d_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASE_BYTES = 225;
    localparam int unsigned DRAIN_CYCLES = 10;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [CP_W-1:0]  acc_value = '0;
    logic [REM_W-1:0] cont_left = '0;
    logic [LEN_W-1:0] seq_count = '0;

    result_t     pending_results[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned decoded_bytes = 0;
    int unsigned checked_beats = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    utf8_stream_decoder_validator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void queue_result(input status_t st, input logic [CP_W-1:0] cp,
                                         input logic [BYTE_W-1:0] eb,
                                         input logic [LEN_W-1:0] len);
        result_t r;
        r.status = st;
        r.char_value = cp;
        r.error_byte = eb;
        r.sequence_length = len;
        pending_results.push_back(r);
    endfunction

    // Returns 0 only for a stray continuation byte, which the decoder drops.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b);
        if (b < 8'h80)
        begin
            if (cont_left != 0)
            begin
                cont_left = '0;
                queue_result(ST_EXPECT_CONT, '0, b, 3'd1);
            end
            else
                queue_result(ST_VALID, CP_W'(b), b, 3'd1);
        end
        else if (b[7:6] == 2'b10)
        begin
            if (cont_left == 0)
                return 1'b0;
            acc_value = {acc_value[CP_W-7:0], b[5:0]};
            seq_count = seq_count + 3'd1;
            cont_left = cont_left - 2'd1;
            if (cont_left == 0)
            begin
                if (acc_value > CP_MAX)
                    queue_result(ST_OUT_OF_RANGE, acc_value, b, seq_count);
                else if (acc_value >= SURR_LO && acc_value <= SURR_HI)
                    queue_result(ST_SURROGATE, acc_value, b, seq_count);
                else if ((acc_value < MIN_2BYTE && seq_count > 3'd1) ||
                         (acc_value < MIN_3BYTE && seq_count > 3'd2) ||
                         (acc_value < MIN_4BYTE && seq_count > 3'd3))
                    queue_result(ST_OVERLONG, acc_value, b, seq_count);
                else
                    queue_result(ST_VALID, acc_value, b, seq_count);
            end
        end
        else if (b >= 8'hF8)
        begin
            cont_left = '0;
            queue_result(ST_INVALID_BYTE, '0, b, 3'd1);
        end
        else if (cont_left != 0)
            cont_left = '0;
        else
        begin
            if (b[7:5] == 3'b110)
            begin
                cont_left = 2'd1;
                acc_value = CP_W'(b[4:0]);
            end
            else if (b[7:4] == 4'b1110)
            begin
                cont_left = 2'd2;
                acc_value = CP_W'(b[3:0]);
            end
            else
            begin
                cont_left = 2'd3;
                acc_value = CP_W'(b[2:0]);
            end
            seq_count = 3'd1;
        end
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (decode_byte(b))
            decoded_bytes++;
    endtask

    task automatic send_code_point(input logic [CP_W-1:0] cp, input int unsigned len);
        case (len)
            1: send_byte({1'b0, cp[6:0]});
            2:
            begin
                send_byte({3'b110, cp[10:6]});
                send_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                send_byte({4'b1110, cp[15:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                send_byte({5'b11110, cp[20:18]});
                send_byte({2'b10, cp[17:12]});
                send_byte({2'b10, cp[11:6]});
                send_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat 0x%0h arrived with no result pending", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_axis_tdata[2:0]);
                check_field("char_value", want.char_value, m_axis_tdata[23:3]);
                check_field("error_byte", want.error_byte, m_axis_tdata[31:24]);
                check_field("sequence_length", want.sequence_length, m_axis_tdata[34:32]);
                check_field("padding", 0, m_axis_tdata[OUT_TDATA_W-1:35]);
                checked_beats++;
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_ascii_extremes();
        send_byte(8'h00);
        send_byte(8'h7F);
    endtask

    task automatic test_valid_sequences();
        send_code_point(21'h000080, 2);
        send_code_point(21'h0020AC, 3);
        send_code_point(21'h10FFFF, 4);
    endtask

    task automatic test_decode_errors();
        send_code_point(21'h110000, 4);
        send_code_point(21'h00D800, 3);
        send_code_point(21'h00007F, 2);
        send_code_point(21'h00FFFF, 4);
        send_byte(8'hFF);
    endtask

    task automatic test_broken_sequences();
        send_byte(8'hC2);
        send_byte(8'h41);
        send_byte(8'h80);
        send_byte(8'hE2);
        send_byte(8'hC2);
        send_byte(8'hE2);
        send_byte(8'hF8);
    endtask

    task automatic send_random_unit();
        int unsigned kind;
        int unsigned len;
        int unsigned cut;
        logic [BYTE_W-1:0] lead;
        logic [CP_W-1:0] cp;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            len = $urandom_range(1, 4);
            case (len)
                1: cp = CP_W'($urandom_range(0, 'h7F));
                2: cp = CP_W'($urandom_range('h80, 'h7FF));
                3:
                begin
                    do
                        cp = CP_W'($urandom_range('h800, 'hFFFF));
                    while (cp >= SURR_LO && cp <= SURR_HI);
                end
                default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
            endcase
            send_code_point(cp, len);
        end
        else if (kind < 80)
        begin
            lead = BYTE_W'($urandom_range('hC0, 'hF7));
            len = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
            cut = (kind < 70) ? len : $urandom_range(0, len - 1);
            send_byte(lead);
            repeat (cut)
                send_byte({2'b10, 6'($urandom_range(0, 63))});
            if (cut < len)
                send_byte(BYTE_W'($urandom_range(0, 255)));
        end
        else if (kind < 90)
        begin
            len = $urandom_range(2, 4);
            cp = CP_W'($urandom_range(0, (len == 2) ? 'h7FF : (len == 3) ? 'hFFFF : 'h1FFFFF));
            send_code_point(cp, len);
        end
        else
            send_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic test_random_stream(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned start_count;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start_count = decoded_bytes;
        while (decoded_bytes - start_count < PHASE_BYTES)
            send_random_unit();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ascii_extremes();
        test_valid_sequences();
        test_decode_errors();
        test_broken_sequences();
        test_random_stream(0, 0);
        test_random_stream(57, 0);
        test_random_stream(0, 57);
        test_random_stream(19, 19);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d decoded bytes and checked %0d result beats under four",
                 decoded_bytes, checked_beats);
        $display("flow-control phases, covering valid, error and broken sequences.");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
